// ===== rtl/aea_pkg.sv =====
// Shared constants and types for the array element address block.
package aea_pkg;

  localparam int MAX_ARRAYS = 256;
  localparam int MAX_DIMS   = 10;

  localparam int ID_W    = 8;
  localparam int DIM_W   = 4;
  localparam int WORD_W  = 32;
  localparam int ESIZE_W = 16;
  localparam int HDR_ADDR_W = $clog2(MAX_ARRAYS);
  localparam int SLOT_W  = $clog2(MAX_ARRAYS * MAX_DIMS);

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 40;

  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_BOUNDS = 2'd1;
  localparam logic [1:0] OP_INDEX  = 2'd2;

  // Access request from the control logic to the descriptor tables.
  typedef struct packed {
    logic                  hdr_we;
    logic                  bnd_we;
    logic                  rd_en;
    logic [HDR_ADDR_W-1:0] hdr_addr;
    logic [SLOT_W-1:0]     slot;
    logic [WORD_W-1:0]     base;
    logic [ESIZE_W-1:0]    elem_size;
    logic [DIM_W-1:0]      dim_count;
    logic [WORD_W-1:0]     lower;
    logic [WORD_W-1:0]     upper;
  } tbl_req_t;

  // Registered read data of one descriptor entry and one dimension slot.
  typedef struct packed {
    logic [WORD_W-1:0]  base;
    logic [ESIZE_W-1:0] elem_size;
    logic [DIM_W-1:0]   dim_count;
    logic [WORD_W-1:0]  lower;
    logic [WORD_W-1:0]  upper;
  } tbl_rd_t;

endpackage

// ===== rtl/aea_tables.sv =====
// Descriptor header memory and dimension bounds memory, with registered read data.
module aea_tables
  import aea_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output tbl_rd_t  rd
);

  localparam int HDR_W = WORD_W + ESIZE_W + DIM_W;
  localparam int BND_W = 2 * WORD_W;

  logic [HDR_W-1:0] hdr_mem [MAX_ARRAYS];
  logic [BND_W-1:0] bnd_mem [MAX_ARRAYS * MAX_DIMS];
  logic [HDR_W-1:0] hdr_q_r;
  logic [BND_W-1:0] bnd_q_r;

  always_ff @(posedge clk) begin
    if (req.hdr_we) begin
      hdr_mem[req.hdr_addr] <= {req.base, req.elem_size, req.dim_count};
    end
    if (req.rd_en) begin
      hdr_q_r <= hdr_mem[req.hdr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.bnd_we) begin
      bnd_mem[req.slot] <= {req.upper, req.lower};
    end
    if (req.rd_en) begin
      bnd_q_r <= bnd_mem[req.slot];
    end
  end

  assign rd.base      = hdr_q_r[HDR_W-1 -: WORD_W];
  assign rd.elem_size = hdr_q_r[DIM_W +: ESIZE_W];
  assign rd.dim_count = hdr_q_r[DIM_W-1:0];
  assign rd.lower     = bnd_q_r[WORD_W-1:0];
  assign rd.upper     = bnd_q_r[BND_W-1 -: WORD_W];

endmodule

// ===== rtl/array_element_address_top.sv =====
// Row-major array element address unit: descriptor tables plus Horner accumulator.
//
// Input words carry an operation in in_tuser: define a descriptor header, set the
// bounds of one dimension, or present one subscript of a query. Subscripts arrive
// in dimension order; a subscript for dimension 0 starts a new accumulation.
// After the subscript of the last dimension one result word leaves on the out_
// channel with the descriptor number and base + offset * element size.
// Header and bounds words are written in their accept cycle. For a subscript
// the descriptor memories are read in the accept cycle, and the multiply-add
// on the accumulator follows. The last subscript adds a further step for the
// element-size multiply into the output register.
// The output register lets the block accept further words while a result
// waits; if a new result is ready while the old one is still held, the block
// waits in its final step until the receiver takes the old word.
// Reset clears the control state, the output valid and the accumulator. The
// descriptor memories are not cleared; a query must only use written entries.
// Arithmetic wraps modulo 2^32.
module array_element_address_top
  import aea_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // array_id, dim, base_addr, elem_size, dim_count, lower_bound, upper_bound,
  // index_value
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_array_id, address
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_ADDR = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic [ID_W-1:0]   in_id;
  logic [DIM_W-1:0]  in_dim;
  logic [WORD_W-1:0] in_index;
  logic              accept, id_ok, dim_ok;

  logic [ID_W-1:0]   id_r;
  logic [DIM_W-1:0]  dim_r;
  logic [WORD_W-1:0] index_r;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] term, span, prod;
  logic [DIM_W:0]    dim_plus1;
  logic              last_dim;

  logic                  out_valid_r;
  logic [ID_W-1:0]       out_id_r;
  logic [WORD_W-1:0]     out_addr_r;
  logic [WORD_W-1:0]     addr_calc;
  logic                  out_load;

  tbl_req_t req;
  tbl_rd_t  rd;

  assign in_id    = in_tdata[7:0];
  assign in_dim   = in_tdata[11:8];
  assign in_index = in_tdata[159:128];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign id_ok     = (int'(in_id) < MAX_ARRAYS);
  assign dim_ok    = (int'(in_dim) < MAX_DIMS);

  always_comb begin
    req.hdr_addr  = HDR_ADDR_W'(in_id);
    req.slot      = SLOT_W'(int'(in_id) * MAX_DIMS + int'(in_dim));
    req.base      = in_tdata[43:12];
    req.elem_size = in_tdata[59:44];
    req.dim_count = in_tdata[63:60];
    req.lower     = in_tdata[95:64];
    req.upper     = in_tdata[127:96];
    req.hdr_we    = accept && id_ok && (in_tuser == OP_HEADER);
    req.bnd_we    = accept && id_ok && dim_ok && (in_tuser == OP_BOUNDS);
    req.rd_en     = accept && id_ok && dim_ok && (in_tuser == OP_INDEX);
  end

  aea_tables u_tables (
    .clk (clk),
    .req (req),
    .rd  (rd)
  );

  // Horner step on the accumulator, using the bounds read in the accept cycle.
  always_comb begin
    term      = index_r - rd.lower;
    span      = rd.upper - rd.lower + WORD_W'(1);
    prod      = acc_r * span;
    acc_nxt   = (dim_r == '0) ? term : prod + term;
    dim_plus1 = {1'b0, dim_r} + (DIM_W+1)'(1);
    last_dim  = (dim_plus1 == {1'b0, rd.dim_count});
  end

  assign addr_calc = rd.base + acc_r * {{(WORD_W-ESIZE_W){1'b0}}, rd.elem_size};
  assign out_load  = (state_r == S_ADDR) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (req.rd_en) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        state_nxt = last_dim ? S_ADDR : S_IDLE;
      end
      S_ADDR: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ACC) begin
        acc_r <= acc_nxt;
      end else if (out_load) begin
        acc_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      id_r    <= in_id;
      dim_r   <= in_dim;
      index_r <= in_index;
    end
    if (out_load) begin
      out_id_r   <= id_r;
      out_addr_r <= addr_calc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_addr_r, out_id_r};

endmodule
